@@ sv/npem_pkg.sv @@
// Shared types and constants for the nearest-point efficiency map.
package npem_pkg;

  localparam int MAX_COLUMNS_DEF = 32;
  localparam int MAX_ROWS_DEF    = 32;
  localparam int CFG_RESET       = 32;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 6;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 1'b1;

  localparam logic [1:0] OP_LOAD_AXIS = 2'd0;
  localparam logic [1:0] OP_LOAD_CELL = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  // Divide by 25600: round offset, shift by 256, then reciprocal of 100.
  localparam int          PCT_HALF    = 12800;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_MUL   = 24'd10737419;
  localparam logic [16:0] SAT_POS     = 17'd32767;
  localparam logic [16:0] SAT_NEG_MAG = 17'd32768;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] axis_rpm;
    logic signed [15:0] cell_torque;
    logic [14:0]        cell_efficiency;
    logic signed [15:0] query_rpm;
    logic signed [15:0] query_torque;
  } item_t;

  typedef struct packed {
    logic signed [15:0] effective_torque;
    logic [14:0]        efficiency;
    logic [4:0]         rpm_point;
    logic [4:0]         torque_point;
  } result_t;

  typedef enum logic [1:0] {
    CMD_AXIS,
    CMD_CELL,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [14:0]        eff;
  } cmd_t;

endpackage

@@ sv/npem_front.sv @@
// Front end: takes input transfers, drops out-of-range loads and unknown ops, builds back-end commands.
module npem_front import npem_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic  start,
  input  logic  busy,
  input  item_t item,
  output logic  push,
  output cmd_t  cmd
);

  logic col_ok;
  logic row_ok;
  logic keep;

  assign col_ok = int'(item.col_index) < MAX_COLUMNS;
  assign row_ok = int'(item.row_index) < MAX_ROWS;

  always_comb begin
    cmd.kind = CMD_QUERY;
    cmd.row  = item.row_index;
    cmd.col  = item.col_index;
    cmd.a    = item.query_rpm;
    cmd.b    = item.query_torque;
    cmd.eff  = item.cell_efficiency;
    keep     = 1'b0;
    unique case (item.op)
      OP_LOAD_AXIS: begin
        cmd.kind = CMD_AXIS;
        cmd.a    = item.axis_rpm;
        keep     = col_ok;
      end
      OP_LOAD_CELL: begin
        cmd.kind = CMD_CELL;
        cmd.b    = item.cell_torque;
        keep     = col_ok && row_ok;
      end
      OP_QUERY: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = start && !busy && keep;

endmodule

@@ sv/npem_queue.sv @@
// Short command queue between front end and back end.
module npem_queue import npem_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             slots [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head  = slots[rd_ptr];
  assign full  = int'(count) == QUEUE_DEPTH;
  assign empty = count == '0;

endmodule

@@ sv/npem_engine.sv @@
// Back end: map memories, two nearest-point scans and the scaled torque result.
module npem_engine import npem_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  localparam int CNW = $clog2(MAX_COLUMNS + 1),
  localparam int RNW = $clog2(MAX_ROWS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  cmd_t           head,
  output logic           pop,
  input  logic [CNW-1:0] ncol,
  input  logic [RNW-1:0] nrow,
  output logic           done,
  output result_t        result
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW = (CNW > RW) ? ((CNW > RNW) ? CNW : RNW) : ((RW > RNW) ? RW : RNW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL,
    S_ROW,
    S_FETCH,
    S_MUL,
    S_ABS,
    S_RECIP,
    S_OUT
  } state_t;

  state_t state;

  logic signed [15:0] axis_mem [2**CW];
  logic [30:0]        cell_mem [2**(RW+CW)];
  logic signed [15:0] axis_rd;
  logic [30:0]        cell_rd;

  logic               axis_we;
  logic               cell_we;
  logic [RW+CW-1:0]   cell_wa;
  logic [RW+CW-1:0]   cell_ra;

  logic signed [15:0] qr;
  logic signed [15:0] qt;
  logic [SW-1:0]      scan_idx;
  logic [SW-1:0]      pipe_idx;
  logic               pipe_valid;
  logic [16:0]        best_d;
  logic [CW-1:0]      best_c;
  logic [RW-1:0]      best_r;
  logic [14:0]        eff_r;
  logic signed [31:0] prod;
  logic               neg;
  logic [22:0]        v;
  logic [46:0]        qmul;

  logic [SW-1:0]      limit;
  logic signed [15:0] cand;
  logic signed [15:0] target;
  logic signed [16:0] diff;
  logic [16:0]        gap;
  logic signed [31:0] rsum;
  logic [16:0]        quot;
  logic [16:0]        quot_neg;

  assign pop     = (state == S_IDLE) && !q_empty;
  assign axis_we = pop && (head.kind == CMD_AXIS);
  assign cell_we = pop && (head.kind == CMD_CELL);
  assign cell_wa = {RW'(head.row), CW'(head.col)};
  assign cell_ra = (state == S_FETCH) ? {best_r, best_c} : {scan_idx[RW-1:0], best_c};

  always_ff @(posedge clk) begin
    if (axis_we) begin
      axis_mem[CW'(head.col)] <= head.a;
    end
    if (cell_we) begin
      cell_mem[cell_wa] <= {head.b, head.eff};
    end
    axis_rd <= axis_mem[scan_idx[CW-1:0]];
    cell_rd <= cell_mem[cell_ra];
  end

  assign limit  = (state == S_COL) ? SW'(ncol) : SW'(nrow);
  assign cand   = (state == S_COL) ? axis_rd : $signed(cell_rd[30:15]);
  assign target = (state == S_COL) ? qr : qt;
  assign diff   = {cand[15], cand} - {target[15], target};
  assign gap    = diff[16] ? 17'(-diff) : 17'(diff);

  // round half away from zero on the magnitude
  assign rsum     = prod[31] ? 32'(PCT_HALF) - prod : prod + 32'(PCT_HALF);
  assign quot     = qmul[46:RECIP_SHIFT];
  assign quot_neg = 17'(-quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      pipe_valid <= 1'b0;
      scan_idx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty && head.kind == CMD_QUERY) begin
            qr         <= head.a;
            qt         <= head.b;
            scan_idx   <= '0;
            pipe_valid <= 1'b0;
            state      <= S_COL;
          end
        end
        S_COL, S_ROW: begin
          if (scan_idx < limit) begin
            pipe_valid <= 1'b1;
            pipe_idx   <= scan_idx;
            scan_idx   <= scan_idx + 1'b1;
          end else begin
            pipe_valid <= 1'b0;
          end
          if (pipe_valid) begin
            if (pipe_idx == '0 || gap < best_d) begin
              best_d <= gap;
              if (state == S_COL) begin
                best_c <= CW'(pipe_idx);
              end else begin
                best_r <= RW'(pipe_idx);
              end
            end
            if (pipe_idx == SW'(limit - 1'b1)) begin
              scan_idx   <= '0;
              pipe_valid <= 1'b0;
              state      <= (state == S_COL) ? S_ROW : S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_MUL;
        end
        S_MUL: begin
          eff_r <= cell_rd[14:0];
          prod  <= qt * $signed({1'b0, cell_rd[14:0]});
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= prod[31];
          v     <= rsum[30:8];
          state <= S_RECIP;
        end
        S_RECIP: begin
          qmul  <= v * RECIP_MUL;
          state <= S_OUT;
        end
        S_OUT: begin
          if (neg) begin
            result.effective_torque <= (quot > SAT_NEG_MAG) ? $signed(SAT_NEG_MAG[15:0])
                                                            : $signed(quot_neg[15:0]);
          end else begin
            result.effective_torque <= (quot > SAT_POS) ? $signed(SAT_POS[15:0])
                                                        : $signed(quot[15:0]);
          end
          result.efficiency   <= eff_r;
          result.rpm_point    <= 5'(best_c);
          result.torque_point <= 5'(best_r);
          done                <= 1'b1;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/nearest_point_efficiency_map_core.sv @@
// Top level of the nearest-point efficiency map: config registers, front, queue, back end.
// Loads are written to the map as they leave the queue, which happens only while the back end is idle.
// A query scans columns, then rows, then fetches, multiplies, rounds, scales and strobes done.
// Queries run one at a time, each with sequential column and row scans.
// busy rises only while the two-entry command queue is full; results cannot be held off.
// Reset clears control state; counts go to min(32, map size); map is undefined until loaded.
module nearest_point_efficiency_map_core import npem_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   done,
  output result_t                result,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam logic [CNW-1:0] NCOL_RST =
    CNW'((CFG_RESET > MAX_COLUMNS) ? MAX_COLUMNS : CFG_RESET);
  localparam logic [RNW-1:0] NROW_RST =
    RNW'((CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET);

  logic [CNW-1:0] ncol;
  logic [RNW-1:0] nrow;
  logic [CNW-1:0] ncol_wr;
  logic [RNW-1:0] nrow_wr;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_head;

  // zero counts as one, above the map size counts as the map size
  assign ncol_wr = (wr_data == '0) ? CNW'(1) :
                   (int'(wr_data) > MAX_COLUMNS) ? CNW'(MAX_COLUMNS) : CNW'(wr_data);
  assign nrow_wr = (wr_data == '0) ? RNW'(1) :
                   (int'(wr_data) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      ncol <= NCOL_RST;
      nrow <= NROW_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_COLUMNS: ncol <= ncol_wr;
        CFG_ROWS:    nrow <= nrow_wr;
        default:     ncol <= ncol;
      endcase
    end
  end

  assign busy = q_full;

  npem_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (q_push),
    .cmd   (q_wdata)
  );

  npem_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  npem_engine #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (q_head),
    .pop     (q_pop),
    .ncol    (ncol),
    .nrow    (nrow),
    .done    (done),
    .result  (result)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_single_result: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_idle_after_reset: assert property (@(posedge clk) $past(rst) |-> !busy && !done)
    else $error("busy or done set right after reset");

endmodule
